FILE: rtl/core/dvs_pkg.sv
package dvs_pkg;

  localparam int unsigned ValueWidth = 32;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         last;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] sorted_value;
    logic                         final_res;
    logic                         overflow;
  } out_item_t;

  // What every cell of the chain does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e                     op;
    logic signed [ValueWidth-1:0] value;
  } cell_ctrl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         valid;
    logic                         ins;
  } cell_link_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } dvs_state_e;

endpackage

FILE: rtl/core/dvs_cell.sv
module dvs_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dvs_pkg::cell_ctrl_t ctrl_i,
  input  dvs_pkg::cell_link_t left_i,
  input  dvs_pkg::cell_link_t right_i,
  output dvs_pkg::cell_link_t link_o,
  output logic                eq_o
);
  import dvs_pkg::*;

  logic signed [ValueWidth-1:0] val_q, val_d;
  logic                         valid_q, valid_d;
  logic                         ins;

  // The new value belongs here or further left: this cell makes room.
  assign ins  = !valid_q || (ctrl_i.value < val_q);
  assign eq_o = valid_q && (val_q == ctrl_i.value);

  assign link_o.value = val_q;
  assign link_o.valid = valid_q;
  assign link_o.ins   = ins;

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        // Take the left neighbor's value if it moves right, else take the new one.
        if (left_i.ins) begin
          val_d = left_i.value;
        end else if (ins) begin
          val_d = ctrl_i.value;
        end
        valid_d = valid_q | left_i.valid;
      end
      CELL_SHIFT: begin
        val_d   = right_i.value;
        valid_d = right_i.valid;
      end
      default: begin
        val_d   = val_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

FILE: rtl/core/distinct_value_sorter.sv
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_stall_o    | in_data_i  (value, last)
// out     | output    | out_valid_o / out_stall_i  | out_data_o (sorted_value, final_res, overflow)
//
// An item not marked last is inserted into the cell chain in the cycle it is accepted, unless
// its value is already held or the chain is full. A marked item is inserted alike, then the set
// drains one result per cycle while the output is not stalled, with the input channel stalled.
// Reset clears the valid bit of every cell, the overflow flag and the output valid flag.
// A stall on the output holds the chain and the output register until the result is taken.
module distinct_value_sorter #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dvs_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dvs_pkg::out_item_t out_data_o
);
  import dvs_pkg::*;

  dvs_state_e state_q, state_d;

  cell_ctrl_t cell_ctrl;
  cell_link_t link [DEPTH];
  logic [DEPTH-1:0] eq_vec;
  logic [DEPTH-1:0] valid_vec;

  logic in_take;   // input transaction this cycle
  logic out_load;  // move the head of the chain into the output register
  logic dup;       // value already held
  logic full;      // every cell holds a value
  logic is_final;  // the head is the last held value

  logic      ovf_q, ovf_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;

  // Chain of cells: cell 0 holds the smallest value. On insert every cell compares the
  // broadcast value with its own, and cells at and above the insert point shift right.
  // On emit the chain shifts left by one per result.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    cell_link_t left_link;
    cell_link_t right_link;

    if (k == 0) begin : g_left_end
      // Nothing sits left of the head; its stand-in neighbor is always occupied and never moves right.
      assign left_link = '{value: '0, valid: 1'b1, ins: 1'b0};
    end else begin : g_left
      assign left_link = link[k-1];
    end

    if (k == DEPTH - 1) begin : g_right_end
      // Shift an empty entry into the tail while draining.
      assign right_link = '{value: '0, valid: 1'b0, ins: 1'b1};
    end else begin : g_right
      assign right_link = link[k+1];
    end

    dvs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .left_i  (left_link),
      .right_i (right_link),
      .link_o  (link[k]),
      .eq_o    (eq_vec[k])
    );

    assign valid_vec[k] = link[k].valid;
  end

  assign dup      = |eq_vec;
  assign full     = valid_vec[DEPTH-1];
  assign is_final = !valid_vec[1];

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_take    = in_valid_i && !in_stall_o;

  // Load a new result when the output register is empty or being emptied.
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_take && in_data_i.last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && is_final) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Chain control: insert a new distinct value while there is room, drain on emit.
  always_comb begin
    cell_ctrl.value = in_data_i.value;
    cell_ctrl.op    = CELL_HOLD;
    case (state_q)
      ST_LOAD: begin
        if (in_take && !dup && !full) begin
          cell_ctrl.op = CELL_INSERT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          cell_ctrl.op = CELL_SHIFT;
        end
      end
      default: begin
        cell_ctrl.op = CELL_HOLD;
      end
    endcase
  end

  // Overflow: set when a distinct value finds the chain full, drop after the final result.
  always_comb begin
    ovf_d = ovf_q;
    if (in_take && !dup && full) begin
      ovf_d = 1'b1;
    end else if (out_load && is_final) begin
      ovf_d = 1'b0;
    end
  end

  // Hold the output while stalled, drop it once taken.
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.sorted_value <= link[0].value;
      out_data_q.final_res    <= is_final;
      out_data_q.overflow     <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Occupied cells always form a prefix of the chain.
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, valid_vec} + {{DEPTH{1'b0}}, 1'b1}))
    else $error("cell chain has a hole");

  // While draining, the head of the chain holds a value.
  a_emit_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> valid_vec[0])
    else $error("emit with empty chain head");

  // After the final result the chain is empty.
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && is_final) |=> (valid_vec == '0))
    else $error("chain not empty after final result");

  // Overflow only rises when a value met a full chain.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(full))
    else $error("overflow set without a full chain");

endmodule

FILE: sim/tb_distinct_value_sorter.sv
module tb_distinct_value_sorter;
  import dvs_pkg::*;

  localparam int unsigned STORE_DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 300;
  // Longest quiet stretch allowed: covers the long receiver hold-off, long gaps on
  // both sides and the drain pauses, several times over.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned SETTLE_CYCLES = 20;

  localparam logic signed [ValueWidth-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ValueWidth-1:0] VAL_MAX = 32'sh7fff_ffff;

  // One entry of the sender's backlog; drain_first holds it back until the
  // block has handed over every pending result.
  typedef struct {
    in_item_t item;
    bit       drain_first;
  } send_entry_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  send_entry_t             pending_items[$];
  out_item_t               expected_sorted[$];
  logic signed [ValueWidth-1:0] held_vals[$];
  bit                      set_overflow = 1'b0;

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned sets_closed = 0;
  int unsigned overflow_sets = 0;
  int unsigned total_items = 0;
  int unsigned quiet_cycles = 0;

  int unsigned send_gap = 0;
  int unsigned drain_wait = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          long_hold_done = 1'b0;

  distinct_value_sorter #(
    .DEPTH(STORE_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Fold one accepted item into the sorted store; on the marked item, queue the
  // whole ordered set as expected results and clear the store.
  function automatic void absorb_value(in_item_t it);
    logic signed [ValueWidth-1:0] v;
    int unsigned pos;
    out_item_t res;
    v = it.value;
    pos = 0;
    while (pos < held_vals.size() && held_vals[pos] < v) pos++;
    if (!(pos < held_vals.size() && held_vals[pos] == v)) begin
      // A full store keeps what it has, even when the newcomer is smaller.
      if (held_vals.size() >= STORE_DEPTH) set_overflow = 1'b1;
      else held_vals.insert(pos, v);
    end
    if (it.last) begin
      for (int k = 0; k < held_vals.size(); k++) begin
        res.sorted_value = held_vals[k];
        res.final_res    = (k == held_vals.size() - 1);
        res.overflow     = set_overflow;
        expected_sorted.push_back(res);
      end
      sets_closed++;
      if (set_overflow) overflow_sets++;
      held_vals.delete();
      set_overflow = 1'b0;
    end
  endfunction

  task automatic queue_item(input logic signed [ValueWidth-1:0] v, input logic last,
                            input bit drain_first);
    send_entry_t e;
    e.item.value = v;
    e.item.last = last;
    e.drain_first = drain_first;
    pending_items.push_back(e);
  endtask

  // Driver: predict on every accepted transaction, then offer the next item or idle.
  // Hold the payload steady while the block stalls.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    send_entry_t nxt;
    bit calm;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      calm = ((items_sent / 40) % 4) == 1;
      if (in_valid_i && !in_stall_o) begin
        absorb_value(in_data_i);
        items_sent++;
        send_gap = calm ? 0 : pick_gap();
      end
      // Count quiet cycles while a drain pause is due and nothing is owed.
      if (pending_items.size() > 0 && pending_items[0].drain_first &&
          expected_sorted.size() == 0)
        drain_wait++;
      else
        drain_wait = 0;
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].drain_first || drain_wait >= SETTLE_CYCLES)) begin
          nxt = pending_items.pop_front();
          drain_wait = 0;
          in_valid_i <= 1'b1;
          in_data_i <= nxt.item;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation, then
  // choose the stall for the next cycle.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_item_t want;
    int unsigned r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_sorted.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: value %0d final %0b overflow %0b",
                     out_data_o.sorted_value, out_data_o.final_res, out_data_o.overflow);
        end else begin
          want = expected_sorted.pop_front();
          if (out_data_o.sorted_value !== want.sorted_value ||
              out_data_o.final_res !== want.final_res ||
              out_data_o.overflow !== want.overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $write("result %0d: expected value %0d final %0b overflow %0b, ",
                     results_seen, want.sorted_value, want.final_res, want.overflow);
              $display("got value %0d final %0b overflow %0b",
                       out_data_o.sorted_value, out_data_o.final_res, out_data_o.overflow);
            end
          end
        end
      end
      // Hold off once for a long stretch so the block backs up onto its input.
      if (!long_hold_done && results_seen >= 80) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (((results_seen / 48) % 3) == 2) begin
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          stall_left = pick_gap();
          out_stall_i <= (stall_left > 0);
          if (stall_left > 0) stall_left--;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned set_len;
    int unsigned set_idx;
    int unsigned r;
    int unsigned leftover;
    logic signed [ValueWidth-1:0] v;

    // Lone item that opens and closes its set, at the most negative value.
    queue_item(VAL_MIN, 1'b1, 1'b0);
    // Extremes, zero and minus one; repeat the top value, close on a repeat.
    queue_item(VAL_MAX, 1'b0, 1'b0);
    queue_item(VAL_MIN, 1'b0, 1'b0);
    queue_item(32'sd0, 1'b0, 1'b0);
    queue_item(-32'sd1, 1'b0, 1'b0);
    queue_item(VAL_MAX, 1'b0, 1'b0);
    queue_item(-32'sd1, 1'b1, 1'b0);
    // Set made only of one repeated value.
    queue_item(32'sd5, 1'b0, 1'b0);
    queue_item(32'sd5, 1'b1, 1'b0);
    // Fill the store in descending order, then close on a smaller newcomer that
    // gets dropped and flags overflow.
    for (int k = 0; k < STORE_DEPTH; k++)
      queue_item(32'sd1000 - 32'sd10 * k, 1'b0, 1'b0);
    queue_item(-32'sd5000, 1'b1, 1'b0);

    // Random sets: mostly short, some filling the store, a few past its depth.
    set_idx = 0;
    while (pending_items.size() < 25 + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) set_len = $urandom_range(1, 8);
      else if (r < 92) set_len = $urandom_range(9, 16);
      else set_len = $urandom_range(17, 24);
      for (int k = 0; k < set_len; k++) begin
        r = $urandom_range(0, 9);
        case (r)
          0: begin
            case ($urandom_range(0, 3))
              0: v = VAL_MIN;
              1: v = VAL_MAX;
              2: v = 32'sd0;
              default: v = -32'sd1;
            endcase
          end
          1, 2, 3: v = $signed($urandom_range(0, 8)) - 32'sd4;
          default: v = $urandom();
        endcase
        queue_item(v, k == set_len - 1, (k == 0) && (set_idx % 8 == 0));
      end
      set_idx++;
    end
    total_items = pending_items.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_sent < total_items) @(posedge clk_i);
    while (expected_sorted.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    leftover = expected_sorted.size();
    if (leftover != 0)
      $display("%0d expected results never arrived", leftover);
    $display("covered %0d items in %0d sets, %0d of them overflowing the store",
             items_sent, sets_closed, overflow_sets);
    $display("checked %0d sorted results, %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0 && leftover == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
